@@ rtl/dmt_pkg.sv @@
// Shared types, codes and helpers for the XOR delta match table.
// Used by dmt_cell, dmt_ctrl and xor_delta_match_table; depends on nothing.
package dmt_pkg;

   localparam int MAX_BYTES_DEF     = 8;
   localparam int TABLE_ENTRIES_DEF = 16;

   // fixed field widths
   localparam int DATA_W  = 64;
   localparam int STAMP_W = 32;
   localparam int CLS_W   = 3;   // holds class index for MAX_BYTES up to 8
   localparam int SLOT_W  = 8;   // holds slot index for TABLE_ENTRIES up to 256
   localparam int OSLOT_W = 4;

   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

   typedef enum logic [1:0] {
      MODE_FIND     = 2'd0,
      MODE_ADD_NEW  = 2'd1,
      MODE_ADD_DIFF = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_NONE   = 2'd0,
      STAT_DIFF   = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_STORED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // operation held steady for the whole scan
   typedef struct packed {
      mode_type            mode;
      logic [CLS_W-1:0]    cls;
      logic [DATA_W-1:0]   old_v;
      logic [DATA_W-1:0]   new_v;
      logic [DATA_W-1:0]   diff_v;
      logic [STAMP_W-1:0]  stamp;
   } query_type;

   // scan state handed from cell to cell
   typedef struct packed {
      logic                busy;
      logic                collision;
      logic                found;
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [STAMP_W-1:0]  best_stamp;
      logic [SLOT_W-1:0]   best_slot;
   } token_type;

   typedef struct packed {
      logic                en;
      logic [SLOT_W-1:0]   slot;
   } write_type;

   // mask keeping the low n bytes
   function automatic logic [DATA_W-1:0] len_mask(input logic [3:0] n);
      logic [DATA_W-1:0] m;
      begin
         if (n >= 4'd8) begin
            m = '1;
         end else begin
            m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
         end
         return m;
      end
   endfunction

endpackage

@@ rtl/dmt_cell.sv @@
// One table slot, holding that slot's entry for every length class.
// Takes the scan token from its left neighbor and passes it on in the next cycle.
// Depends on dmt_pkg.
module dmt_cell #(
   parameter int MAX_BYTES  = dmt_pkg::MAX_BYTES_DEF,
   parameter int SLOT_INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dmt_pkg::query_type    query,
   input  dmt_pkg::write_type    wr,
   input  dmt_pkg::token_type    tok_i,
   output dmt_pkg::token_type    tok_o
);

   localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam logic [dmt_pkg::SLOT_W-1:0] MY_SLOT = dmt_pkg::SLOT_W'(SLOT_INDEX);

   logic                          valid_ff [MAX_BYTES];
   logic [dmt_pkg::STAMP_W-1:0]   stamp_ff [MAX_BYTES];
   logic [dmt_pkg::DATA_W-1:0]    old_ff   [MAX_BYTES];
   logic [dmt_pkg::DATA_W-1:0]    new_ff   [MAX_BYTES];
   logic [dmt_pkg::DATA_W-1:0]    diff_ff  [MAX_BYTES];

   dmt_pkg::token_type            tok_ff;
   dmt_pkg::token_type            tok_in;

   logic [IDX_W-1:0]              idx;
   logic                          ent_valid;
   logic [dmt_pkg::STAMP_W-1:0]   ent_stamp;
   logic                          wr_hit;

   assign idx    = query.cls[IDX_W-1:0];
   assign wr_hit = wr.en && (wr.slot == MY_SLOT);

   always_comb begin
      ent_valid = valid_ff[idx];
      // an unwritten slot counts as stamp zero
      ent_stamp = ent_valid ? stamp_ff[idx] : '0;
      tok_in    = tok_i;
      if (ent_valid && !tok_i.found) begin
         if (diff_ff[idx] == query.diff_v) begin
            tok_in.found  = 1'b1;
            tok_in.slot   = MY_SLOT;
            tok_in.status = (!tok_i.collision && new_ff[idx] == query.new_v) ?
                            dmt_pkg::STAT_FULL : dmt_pkg::STAT_DIFF;
         end else if (old_ff[idx] == query.old_v) begin
            tok_in.collision = 1'b1;
         end
      end
      if (ent_stamp < tok_i.best_stamp) begin
         tok_in.best_stamp = ent_stamp;
         tok_in.best_slot  = MY_SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BYTES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_hit) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         stamp_ff[idx] <= query.stamp;
         old_ff[idx]   <= query.old_v;
         new_ff[idx]   <= query.new_v;
         diff_ff[idx]  <= query.diff_v;
      end
   end

   assign tok_o = tok_ff;

endmodule

@@ rtl/dmt_ctrl.sv @@
// Sequencer: takes a request beat, launches the scan token, applies the
// replacement write and holds the response beat. Depends on dmt_pkg.
module dmt_ctrl #(
   parameter int MAX_BYTES = dmt_pkg::MAX_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [231:0]          req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output dmt_pkg::query_type    query,
   output dmt_pkg::token_type    launch,
   input  dmt_pkg::token_type    last_tok,
   output dmt_pkg::write_type    wr
);

   dmt_pkg::state_type            state_ff, state_in;
   dmt_pkg::query_type            query_ff, query_in;
   dmt_pkg::token_type            launch_ff, launch_in;

   logic                          req_fire;
   logic                          req_ok;
   logic [3:0]                    byte_count;
   logic [dmt_pkg::DATA_W-1:0]    mask, old_m, new_m, diff_m;
   dmt_pkg::mode_type             mode;

   dmt_pkg::status_type           pend_status_ff, pend_status_in;
   logic [dmt_pkg::SLOT_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [dmt_pkg::DATA_W-1:0]    pend_data_ff, pend_data_in;
   logic                          pend_load;

   logic                          rsp_valid_ff, rsp_valid_in;
   dmt_pkg::status_type           rsp_status_ff;
   logic [dmt_pkg::OSLOT_W-1:0]   rsp_slot_ff;
   logic [dmt_pkg::DATA_W-1:0]    rsp_data_ff;
   logic                          rsp_load;

   // request fields
   assign mode       = dmt_pkg::mode_type'(req_tuser);
   assign byte_count = req_tdata[3:0];
   assign mask       = dmt_pkg::len_mask(byte_count);
   assign old_m      = req_tdata[67:4]    & mask;
   assign new_m      = req_tdata[131:68]  & mask;
   assign diff_m     = req_tdata[195:132] & mask;

   assign req_ok = (byte_count >= 4'd1) && (byte_count <= 4'(MAX_BYTES)) &&
                   (mode != dmt_pkg::MODE_UNUSED);
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      query_in        = query_ff;
      query_in.mode   = mode;
      query_in.cls    = dmt_pkg::CLS_W'(byte_count - 4'd1);
      query_in.old_v  = old_m;
      query_in.stamp  = req_tdata[227:196];
      unique case (mode)
         dmt_pkg::MODE_ADD_DIFF: begin
            query_in.diff_v = diff_m;
            query_in.new_v  = old_m ^ diff_m;
         end
         default: begin
            query_in.diff_v = old_m ^ new_m;
            query_in.new_v  = new_m;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      launch_in      = '0;
      wr             = '0;
      pend_load      = 1'b0;
      pend_status_in = dmt_pkg::STAT_NONE;
      pend_slot_in   = '0;
      pend_data_in   = '0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         dmt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_ok) begin
                  launch_in.busy       = 1'b1;
                  launch_in.status     = dmt_pkg::STAT_NONE;
                  launch_in.best_stamp = dmt_pkg::STAMP_MAX;
                  state_in             = dmt_pkg::ST_SCAN;
               end else begin
                  pend_load = 1'b1;      // zero answer, no scan
                  state_in  = dmt_pkg::ST_FINISH;
               end
            end
         end
         dmt_pkg::ST_SCAN: begin
            if (last_tok.busy) begin
               pend_load = 1'b1;
               if (query_ff.mode == dmt_pkg::MODE_FIND) begin
                  pend_status_in = last_tok.status;
                  pend_slot_in   = last_tok.slot;
               end else begin
                  wr.en          = 1'b1;
                  wr.slot        = last_tok.best_slot;
                  pend_status_in = dmt_pkg::STAT_STORED;
                  pend_slot_in   = last_tok.best_slot;
                  pend_data_in   = query_ff.new_v;
               end
               state_in = dmt_pkg::ST_FINISH;
            end
         end
         dmt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = dmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dmt_pkg::ST_IDLE;
         launch_ff.busy <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         query_ff <= query_in;
      end
      if (pend_load) begin
         pend_status_ff <= pend_status_in;
         pend_slot_ff   <= pend_slot_in;
         pend_data_ff   <= pend_data_in;
      end
      if (rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_slot_ff   <= pend_slot_ff[dmt_pkg::OSLOT_W-1:0];
         rsp_data_ff   <= pend_data_ff;
      end
   end

   assign query      = query_ff;
   assign launch     = launch_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff, rsp_slot_ff};

   // the table is only written at the end of a scan
   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == dmt_pkg::ST_SCAN && last_tok.busy))
      else $error("table write outside scan end");

   // scan token only returns while a scan is open
   a_token_scan: assert property (@(posedge clock) disable iff (reset)
      last_tok.busy |-> state_ff == dmt_pkg::ST_SCAN)
      else $error("stray scan token");

   // an accepted beat always leaves idle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != dmt_pkg::ST_IDLE)
      else $error("request accepted without starting work");

   // rebuilt bytes only come with a stored entry
   a_rebuilt_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != dmt_pkg::STAT_STORED) |-> rsp_tdata[67:4] == '0)
      else $error("rebuilt bytes on a find answer");

   // no match reports slot zero
   a_nomatch_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == dmt_pkg::STAT_NONE) |-> rsp_tdata[3:0] == '0)
      else $error("slot set on no match");

endmodule

@@ rtl/xor_delta_match_table.sv @@
// XOR delta match table. One beat in, one beat out. Each operation passes a
// scan token along a row of TABLE_ENTRIES slot cells, one cell per cycle;
// a request with an unused mode or a length out of range skips the scan. The
// next request is accepted only once the current response has moved into the
// output register, which waits while an earlier response still sits
// unaccepted there.
// A find reports full match, difference match or none; an add overwrites the
// first slot with the lowest stamp. The response register lets the next
// request start while the previous response waits. Depends on dmt_pkg,
// dmt_ctrl and dmt_cell.
module xor_delta_match_table #(
   parameter int MAX_BYTES     = dmt_pkg::MAX_BYTES_DEF,
   parameter int TABLE_ENTRIES = dmt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // byte_count[3:0], old_bytes[67:4], new_bytes[131:68], diff_bytes[195:132],
   // usage_stamp[227:196], zero pad [231:228]
   input  logic [231:0]   req_tdata,
   // mode[1:0]
   input  logic [1:0]     req_tuser,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // slot[3:0], rebuilt_bytes[67:4], zero pad [71:68]
   output logic [71:0]    rsp_tdata,
   // status[1:0]
   output logic [1:0]     rsp_tuser
);

   dmt_pkg::query_type    query;
   dmt_pkg::write_type    wr;
   dmt_pkg::token_type    chain [TABLE_ENTRIES+1];

   dmt_ctrl #(
      .MAX_BYTES (MAX_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .query      (query),
      .launch     (chain[0]),
      .last_tok   (chain[TABLE_ENTRIES]),
      .wr         (wr)
   );

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      dmt_cell #(
         .MAX_BYTES  (MAX_BYTES),
         .SLOT_INDEX (g)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .query (query),
         .wr    (wr),
         .tok_i (chain[g]),
         .tok_o (chain[g+1])
      );
   end

endmodule

@@ sim/xor_delta_match_table_test.sv @@
// Self-checking testbench for xor_delta_match_table: directed and random
// find/add traffic checked against a behavioral copy of the per-length tables.
// Depends on dmt_pkg and the xor_delta_match_table RTL.
module xor_delta_match_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB             = dmt_pkg::MAX_BYTES_DEF;
   localparam int NE             = dmt_pkg::TABLE_ENTRIES_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int POOL_CAP       = 24;

   typedef struct {
      logic [1:0]  mode;
      logic [3:0]  byte_count;
      logic [63:0] old_b;
      logic [63:0] new_b;
      logic [63:0] diff_b;
      logic [31:0] stamp;
   } op_item_type;

   typedef struct {
      dmt_pkg::status_type status;
      logic [3:0]          slot;
      logic [63:0]         rebuilt;
   } op_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [231:0]  req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b1;
   logic [71:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;

   // table image, class-major: entry index = (length - 1) * NE + slot
   bit          tbl_valid [NB*NE] = '{default: 1'b0};
   logic [31:0] tbl_stamp [NB*NE] = '{default: '0};
   logic [63:0] tbl_old   [NB*NE];
   logic [63:0] tbl_new   [NB*NE];
   logic [63:0] tbl_diff  [NB*NE];

   op_result_type pending_results[$];
   op_item_type   stored_pairs[$];
   bit          failed = 1'b0;
   int          burst_left = 0;
   int          quiet_cycles = 0;
   logic [31:0] stamp_clock = 32'd1;

   xor_delta_match_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic logic [63:0] byte_lane_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (b < n) m[b*8 +: 8] = 8'hFF;
      end
      return m;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // applies one operation to the table image and returns its response
   function automatic op_result_type match_table_apply(input op_item_type it);
      op_result_type r;
      logic [63:0] m, o, nw, d;
      logic [31:0] low_stamp;
      int          base, k, victim;
      bit          collide, done;
      r.status  = dmt_pkg::STAT_NONE;
      r.slot    = '0;
      r.rebuilt = '0;
      if (it.byte_count >= 1 && it.byte_count <= NB &&
          it.mode != dmt_pkg::MODE_UNUSED) begin
         m    = byte_lane_mask(it.byte_count);
         o    = it.old_b & m;
         nw   = it.new_b & m;
         d    = it.diff_b & m;
         base = (int'(it.byte_count) - 1) * NE;
         if (it.mode == dmt_pkg::MODE_FIND) begin
            collide = 1'b0;
            done    = 1'b0;
            for (int i = 0; i < NE; i++) begin
               k = base + i;
               if (!done && tbl_valid[k]) begin
                  if (tbl_diff[k] == (o ^ nw)) begin
                     r.status = (!collide && tbl_new[k] == nw) ? dmt_pkg::STAT_FULL
                                                                : dmt_pkg::STAT_DIFF;
                     r.slot   = i[3:0];
                     done     = 1'b1;
                  end else if (tbl_old[k] == o) begin
                     collide = 1'b1;
                  end
               end
            end
         end else begin
            // victim: first slot holding the smallest stamp, valid or not
            low_stamp = dmt_pkg::STAMP_MAX;
            victim    = 0;
            for (int i = 0; i < NE; i++) begin
               if (tbl_stamp[base + i] < low_stamp) begin
                  low_stamp = tbl_stamp[base + i];
                  victim    = i;
               end
            end
            k = base + victim;
            if (it.mode == dmt_pkg::MODE_ADD_NEW) begin
               tbl_diff[k] = o ^ nw;
               tbl_new[k]  = nw;
            end else begin
               tbl_diff[k] = d;
               tbl_new[k]  = o ^ d;
            end
            tbl_old[k]   = o;
            tbl_stamp[k] = it.stamp;
            tbl_valid[k] = 1'b1;
            r.status     = dmt_pkg::STAT_STORED;
            r.slot       = victim[3:0];
            r.rebuilt    = tbl_new[k];
         end
      end
      return r;
   endfunction

   function automatic op_item_type make_op(input logic [1:0] mode, input logic [3:0] n,
                                           input logic [63:0] o, input logic [63:0] nw,
                                           input logic [63:0] d, input logic [31:0] s);
      op_item_type it;
      it.mode       = mode;
      it.byte_count = n;
      it.old_b      = o;
      it.new_b      = nw;
      it.diff_b     = d;
      it.stamp      = s;
      return it;
   endfunction

   // drives one request beat in bursts, records the expected response on accept
   task automatic send_item(input op_item_type it);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= it.mode;
      req_tdata  <= {4'b0000, it.stamp, it.diff_b, it.new_b, it.old_b, it.byte_count};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(match_table_apply(it));
      if (it.mode != dmt_pkg::MODE_FIND && it.mode != dmt_pkg::MODE_UNUSED) begin
         stored_pairs.push_back(it);
         if (it.mode == dmt_pkg::MODE_ADD_DIFF) begin
            stored_pairs[$].new_b = it.old_b ^ it.diff_b;
         end
         if (stored_pairs.size() > POOL_CAP) void'(stored_pairs.pop_front());
      end
   endtask

   task automatic wait_all_done();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_and_bad_lengths();
      send_item(make_op(dmt_pkg::MODE_FIND, 4'd1, '1, '0, '0, 32'd0));
      send_item(make_op(dmt_pkg::MODE_FIND, 4'd8, '0, '1, '1, '1));
      send_item(make_op(dmt_pkg::MODE_FIND, 4'd0, rand64(), rand64(), rand64(),
                        $urandom));
      send_item(make_op(dmt_pkg::MODE_ADD_NEW, 4'd9, rand64(), rand64(), rand64(),
                        $urandom));
      send_item(make_op(dmt_pkg::MODE_ADD_DIFF, 4'd15, '1, '1, '1, '1));
      send_item(make_op(dmt_pkg::MODE_UNUSED, 4'd4, rand64(), rand64(), rand64(),
                        $urandom));
   endtask

   task automatic test_store_and_match();
      // garbage above the length must be ignored everywhere
      send_item(make_op(dmt_pkg::MODE_ADD_NEW, 4'd1, 64'hDEAD_BEEF_0000_00FF,
                        64'h1234_5678_9ABC_DE5A, rand64(), 32'd5));
      send_item(make_op(dmt_pkg::MODE_FIND, 4'd1, 64'h0000_0000_0000_00FF,
                        64'hFFFF_FFFF_FFFF_FF5A, rand64(), 32'd0));
      send_item(make_op(dmt_pkg::MODE_FIND, 4'd1, 64'h0000_0000_0000_0001,
                        64'h0000_0000_0000_00A4, '0, 32'd0));
      send_item(make_op(dmt_pkg::MODE_ADD_DIFF, 4'd8, '1, rand64(), '1, '1));
      send_item(make_op(dmt_pkg::MODE_FIND, 4'd8, '1, '0, rand64(), 32'd0));
      send_item(make_op(dmt_pkg::MODE_ADD_NEW, 4'd8, '0, '1, '0, 32'hFFFF_FFFF));
   endtask

   // same old bytes in an earlier slot with another difference demotes a full hit
   task automatic test_collision();
      send_item(make_op(dmt_pkg::MODE_ADD_NEW, 4'd2, 64'h1234, 64'h1234 ^ 64'h00FF,
                        '0, 32'd1));
      send_item(make_op(dmt_pkg::MODE_ADD_NEW, 4'd2, 64'h1234, 64'h1234 ^ 64'h0F0F,
                        '0, 32'd2));
      send_item(make_op(dmt_pkg::MODE_FIND, 4'd2, 64'h1234, 64'h1234 ^ 64'h0F0F,
                        '0, 32'd0));
      send_item(make_op(dmt_pkg::MODE_FIND, 4'd2, 64'hABCD, 64'hABCD ^ 64'h00FF,
                        '0, 32'd0));
      send_item(make_op(dmt_pkg::MODE_FIND, 4'd2, 64'h1234, 64'h1234 ^ 64'h00FF,
                        '0, 32'd0));
   endtask

   task automatic test_replacement();
      send_item(make_op(dmt_pkg::MODE_ADD_NEW, 4'd3, rand64(), rand64(), '0,
                        32'hFFFF_FFFF));
      send_item(make_op(dmt_pkg::MODE_ADD_DIFF, 4'd3, rand64(), '0, rand64(), 32'd0));
      send_item(make_op(dmt_pkg::MODE_ADD_NEW, 4'd3, rand64(), rand64(), '0, 32'd0));
      send_item(make_op(dmt_pkg::MODE_ADD_DIFF, 4'd3, rand64(), '0, rand64(), 32'd7));
   endtask

   task automatic test_random_traffic(input int count);
      op_item_type it, p;
      int unsigned pick;
      logic [63:0] m;
      for (int c = 0; c < count; c++) begin
         it = make_op(dmt_pkg::MODE_FIND, 4'($urandom_range(1, NB)), rand64(), rand64(),
                      rand64(), stamp_clock);
         pick = $urandom_range(0, 99);
         if (pick < 45) it.mode = dmt_pkg::MODE_FIND;
         else if (pick < 70) it.mode = dmt_pkg::MODE_ADD_NEW;
         else if (pick < 95) it.mode = dmt_pkg::MODE_ADD_DIFF;
         else it.mode = dmt_pkg::MODE_UNUSED;
         if (stored_pairs.size() != 0 && $urandom_range(0, 99) < 75) begin
            p = stored_pairs[$urandom_range(0, stored_pairs.size() - 1)];
            it.byte_count = p.byte_count;
            m    = byte_lane_mask(p.byte_count);
            pick = $urandom_range(0, 99);
            if (it.mode == dmt_pkg::MODE_FIND) begin
               if (pick < 40) begin
                  it.old_b = p.old_b;
                  it.new_b = p.new_b;
               end else if (pick < 75) begin
                  it.new_b = it.old_b ^ p.old_b ^ p.new_b;
               end else begin
                  it.old_b = p.old_b;
               end
            end else if (pick < 50) begin
               it.old_b = p.old_b;
            end
            // random bytes above the length
            it.old_b = (it.old_b & m) | (rand64() & ~m);
            it.new_b = (it.new_b & m) | (rand64() & ~m);
         end
         pick = $urandom_range(0, 99);
         if (pick < 5) it.byte_count = 4'd0;
         else if (pick < 10) it.byte_count = 4'($urandom_range(NB + 1, 15));
         pick = $urandom_range(0, 99);
         if (pick < 8) it.stamp = 32'd0;
         else if (pick < 16) it.stamp = 32'hFFFF_FFFF;
         else if (pick < 26) it.stamp = $urandom;
         else stamp_clock = stamp_clock + 32'd1;
         send_item(it);
      end
   endtask

   // sender holds off until the block has answered everything, then resumes
   task automatic test_drained_restart();
      test_random_traffic(12);
      wait_all_done();
      test_random_traffic(12);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_bad_lengths();
      test_store_and_match();
      test_collision();
      test_replacement();
      test_random_traffic(700);
      test_drained_restart();
      test_random_traffic(700);
      wait_all_done();
      repeat (2 * NE + 8) @(posedge clock);
      if (!failed && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // response check on every accepted beat
   always @(posedge clock) begin : check_rsp
      op_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with nothing outstanding: status %0d slot %0d data %h",
                     $time, rsp_tuser, rsp_tdata[3:0], rsp_tdata[67:4]);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
               failed = 1'b1;
            end
            if (rsp_tdata[3:0] !== want.slot) begin
               $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_tdata[3:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[67:4] !== want.rebuilt) begin
               $display("%0t: rebuilt_bytes expected %h actual %h", $time, want.rebuilt,
                        rsp_tdata[67:4]);
               failed = 1'b1;
            end
         end
      end
   end

   // receiver backpressure: free-flowing, random, periodic and mostly-stalled phases
   int unsigned stall_kind = 0;
   int unsigned stall_left = 0;
   int unsigned stall_tick = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      stall_tick++;
      case (stall_kind)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= $urandom_range(0, 1);
         end
         2: begin
            rsp_tready <= (stall_tick % 4 == 0);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

@@ xor_delta_match_table.f @@
rtl/dmt_pkg.sv
rtl/dmt_cell.sv
rtl/dmt_ctrl.sv
rtl/xor_delta_match_table.sv
sim/xor_delta_match_table_test.sv
